@@ src/vrt_pkg.sv @@
`timescale 1ns / 1ps
package vrt_pkg;

    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int COORD_WIDTH_DEF   = 16;

    localparam logic [15:0] MAX_STEPS_RST = 16'd64;
    localparam logic        FUNC_START    = 1'b0;
    localparam logic        FUNC_REPLY    = 1'b1;
    localparam logic [35:0] DSQ_MAX       = 36'hF_FFFF_FFFF;

    // one input item as held in the queue
    typedef struct packed {
        logic             is_start;
        logic [2:0][31:0] pos;
        logic [2:0][15:0] dir;
        logic             occupied;
    } item_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

@@ src/vrt_front.sv @@
`timescale 1ns / 1ps
module vrt_front
    import vrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t item_in,
    input  logic  pop,
    output head_t head
);

    item_t       q_reg [2];
    logic [1:0]  count_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        do_pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |=> (count_reg != 2'd0))
        else $error("queue count jumped from full to empty");
`endif

endmodule

@@ src/vrt_div.sv @@
`timescale 1ns / 1ps
module vrt_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [31:0] quo
);

    // restoring divider, one quotient bit per cycle
    logic [31:0] q_reg;
    logic [15:0] rem_reg;
    logic [15:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic        ge;

    assign trial = {rem_reg, q_reg[31]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            q_reg    <= 32'd0;
            rem_reg  <= 16'd0;
            den_reg  <= 16'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
                q_reg    <= num;
                rem_reg  <= 16'd0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
                q_reg   <= {q_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ src/vrt_back.sv @@
`timescale 1ns / 1ps
module vrt_back
    import vrt_pkg::*;
#(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  head_t              head,
    output logic               pop,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               done_res,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z,
    output logic               hit,
    output logic [2:0]         face,
    output logic [35:0]        dist_sqr
);

    localparam int F  = POS_FRAC_BITS;
    localparam int CW = COORD_WIDTH;
    localparam int CF = CW + F;
    localparam int DW = ((CF > 32) ? CF : 32) + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIVS  = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_SIDE  = 4'd5;
    localparam logic [3:0] S_STEP0 = 4'd6;
    localparam logic [3:0] S_DM    = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]              state_reg;
    logic [1:0]              axis_reg;
    logic [15:0]             max_steps_reg;
    logic [2:0][CW-1:0]      voxel_reg;
    logic [2:0][31:0]        side_reg;
    logic [2:0][31:0]        delta_reg;
    logic [2:0][31:0]        origin_reg;
    logic [2:0][15:0]        dir_reg;
    logic [2:0]              stepneg_reg;
    logic [2:0]              dirpos_reg;
    logic [1:0]              last_axis_reg;
    logic [15:0]             count_reg;
    logic                    walking_reg;
    logic [31:0]             sum_reg;
    logic [33:0]             sqv_reg;
    logic [19:0]             rem_reg;
    logic [17:0]             root_reg;
    logic [4:0]              iter_reg;
    logic [30:0]             m_reg;
    logic                    ovf_reg;
    logic [63:0]             acc_reg;
    logic                    hit_reg;

    logic                    out_valid_reg;
    logic                    out_done_reg;
    logic [2:0][15:0]        out_vox_reg;
    logic                    out_hit_reg;
    logic [2:0]              out_face_reg;
    logic [35:0]             out_dsq_reg;

    // step unit
    logic [1:0]              st_ax;
    logic [32:0]             st_sum;
    logic [2:0][31:0]        side_step;
    logic [2:0][CW-1:0]      vox_step;

    always_comb
    begin
        if (side_reg[0] < side_reg[1] && side_reg[0] < side_reg[2])
        begin
            st_ax = 2'd0;
        end
        else if (side_reg[1] < side_reg[2])
        begin
            st_ax = 2'd1;
        end
        else
        begin
            st_ax = 2'd2;
        end
        st_sum    = {1'b0, side_reg[st_ax]} + {1'b0, delta_reg[st_ax]};
        side_step = side_reg;
        vox_step  = voxel_reg;
        side_step[st_ax] = st_sum[32] ? 32'hFFFF_FFFF : st_sum[31:0];
        vox_step[st_ax]  = stepneg_reg[st_ax] ? voxel_reg[st_ax] - CW'(1)
                                              : voxel_reg[st_ax] + CW'(1);
    end

    // setup arithmetic
    logic signed [31:0]      sq;
    logic [31:0]             sum_add;
    logic [19:0]             sr_t;
    logic [19:0]             sr_trial;
    logic                    sr_ge;
    logic signed [16:0]      dir_ext;
    logic [15:0]             mag;
    logic                    div_start;
    logic                    div_done;
    logic [31:0]             div_quo;
    logic [F-1:0]            frac;
    logic [F:0]              fd;
    logic [F+32:0]           sprod;
    logic [32:0]             sd;

    assign sq       = $signed(dir_reg[axis_reg]) * $signed(dir_reg[axis_reg]);
    assign sum_add  = sum_reg + 32'(sq);
    assign sr_t     = {rem_reg[17:0], sqv_reg[33:32]};
    assign sr_trial = {root_reg, 2'b01};
    assign sr_ge    = (sr_t >= sr_trial);
    assign dir_ext  = 17'($signed(dir_reg[axis_reg]));
    assign mag      = dir_ext[16] ? 16'(-dir_ext) : dir_ext[15:0];
    assign div_start = (state_reg == S_DIVS) && (mag != 16'd0);
    assign frac     = origin_reg[axis_reg][F-1:0];
    assign fd       = stepneg_reg[axis_reg] ? {1'b0, frac} : (F+1)'((1 << F)) - {1'b0, frac};
    assign sprod    = fd * delta_reg[axis_reg];
    assign sd       = sprod[F+32:F];

    vrt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({root_reg[16:0], 15'd0}),
        .den   (mag),
        .done  (div_done),
        .quo   (div_quo)
    );

    // distance arithmetic
    logic signed [DW-1:0]    vfix;
    logic signed [DW-1:0]    dd;
    logic [DW-1:0]           dm;
    logic [61:0]             msq;
    logic [63:0]             acc_fin;
    logic [63:0]             acc_shift;
    logic [35:0]             dsq_fin;

    assign vfix      = DW'($signed(voxel_reg[axis_reg])) <<< F;
    assign dd        = vfix - DW'($signed(origin_reg[axis_reg]));
    assign dm        = dd[DW-1] ? DW'(-dd) : DW'(dd);
    assign msq       = m_reg * m_reg;
    assign acc_fin   = acc_reg;
    assign acc_shift = acc_fin >> F;
    assign dsq_fin   = (ovf_reg || (|acc_shift[63:36])) ? DSQ_MAX : acc_shift[35:0];

    logic out_free;
    logic limit;
    logic out_load;

    assign out_free = !out_valid_reg || !out_stall;
    assign limit    = (count_reg > max_steps_reg) || (count_reg == 16'hFFFF);
    // a new result enters the output register this cycle
    assign out_load = out_free &&
                      (((state_reg == S_IDLE) && head.valid && !head.item.is_start &&
                        walking_reg && !head.item.occupied && !limit) ||
                       (state_reg == S_STEP0) || (state_reg == S_FIN));

    always_comb
    begin
        pop = 1'b0;
        if (state_reg == S_IDLE && head.valid)
        begin
            if (head.item.is_start || !walking_reg ||
                head.item.occupied || limit)
            begin
                pop = 1'b1;
            end
            else
            begin
                pop = out_free;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            max_steps_reg <= MAX_STEPS_RST;
            voxel_reg     <= '0;
            side_reg      <= '0;
            delta_reg     <= '0;
            origin_reg    <= '0;
            dir_reg       <= '0;
            stepneg_reg   <= 3'd0;
            dirpos_reg    <= 3'd0;
            last_axis_reg <= 2'd0;
            count_reg     <= 16'd0;
            walking_reg   <= 1'b0;
            sum_reg       <= 32'd0;
            sqv_reg       <= 34'd0;
            rem_reg       <= 20'd0;
            root_reg      <= 18'd0;
            iter_reg      <= 5'd0;
            m_reg         <= 31'd0;
            ovf_reg       <= 1'b0;
            acc_reg       <= 64'd0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            out_vox_reg   <= '0;
            out_hit_reg   <= 1'b0;
            out_face_reg  <= 3'd0;
            out_dsq_reg   <= 36'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_steps_reg <= cfg_wr_data;
            end
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        if (head.item.is_start)
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                origin_reg[a]  <= head.item.pos[a];
                                dir_reg[a]     <= head.item.dir[a];
                                voxel_reg[a]   <= CW'($signed(head.item.pos[a][31:F]));
                                stepneg_reg[a] <= head.item.dir[a][15];
                                dirpos_reg[a]  <= !head.item.dir[a][15] &&
                                                  (head.item.dir[a] != 16'd0);
                            end
                            count_reg   <= 16'd0;
                            walking_reg <= 1'b1;
                            sum_reg     <= 32'd0;
                            axis_reg    <= 2'd0;
                            state_reg   <= S_SQ;
                        end
                        else if (walking_reg && (head.item.occupied || limit))
                        begin
                            hit_reg   <= head.item.occupied;
                            axis_reg  <= 2'd0;
                            acc_reg   <= 64'd0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_DM;
                        end
                        else if (walking_reg && out_free)
                        begin
                            count_reg     <= count_reg + 16'd1;
                            side_reg      <= side_step;
                            voxel_reg     <= vox_step;
                            last_axis_reg <= st_ax;
                            out_valid_reg <= 1'b1;
                            out_done_reg  <= 1'b0;
                            out_hit_reg   <= 1'b0;
                            out_face_reg  <= 3'd0;
                            out_dsq_reg   <= 36'd0;
                            for (int a = 0; a < 3; a++)
                            begin
                                out_vox_reg[a] <= 16'(vox_step[a]);
                            end
                        end
                    end
                end
                S_SQ:
                begin
                    sum_reg  <= sum_add;
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        sqv_reg   <= {sum_add, 2'b00};
                        rem_reg   <= 20'd0;
                        root_reg  <= 18'd0;
                        iter_reg  <= 5'd0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    sqv_reg  <= {sqv_reg[31:0], 2'b00};
                    rem_reg  <= sr_ge ? (sr_t - sr_trial) : sr_t;
                    root_reg <= {root_reg[16:0], sr_ge};
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'd16)
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= S_DIVS;
                    end
                end
                S_DIVS:
                begin
                    if (mag == 16'd0)
                    begin
                        delta_reg[axis_reg] <= 32'hFFFF_FFFF;
                        state_reg           <= S_SIDE;
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        delta_reg[axis_reg] <= div_quo;
                        state_reg           <= S_SIDE;
                    end
                end
                S_SIDE:
                begin
                    side_reg[axis_reg] <= sd[32] ? 32'hFFFF_FFFF : sd[31:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_STEP0;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_DIVS;
                    end
                end
                S_STEP0:
                begin
                    if (out_free)
                    begin
                        side_reg      <= side_step;
                        voxel_reg     <= vox_step;
                        last_axis_reg <= st_ax;
                        out_valid_reg <= 1'b1;
                        out_done_reg  <= 1'b0;
                        out_hit_reg   <= 1'b0;
                        out_face_reg  <= 3'd0;
                        out_dsq_reg   <= 36'd0;
                        for (int a = 0; a < 3; a++)
                        begin
                            out_vox_reg[a] <= 16'(vox_step[a]);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_DM:
                begin
                    m_reg     <= dm[30:0];
                    ovf_reg   <= ovf_reg || (|dm[DW-1:31]);
                    state_reg <= S_DMUL;
                end
                S_DMUL:
                begin
                    acc_reg <= acc_reg + {2'b00, msq};
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_DM;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        walking_reg   <= 1'b0;
                        out_valid_reg <= 1'b1;
                        out_done_reg  <= 1'b1;
                        out_hit_reg   <= hit_reg;
                        out_face_reg  <= {last_axis_reg, ~dirpos_reg[last_axis_reg]};
                        out_dsq_reg   <= dsq_fin;
                        for (int a = 0; a < 3; a++)
                        begin
                            out_vox_reg[a] <= 16'(voxel_reg[a]);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = out_done_reg;
    assign voxel_x   = $signed(out_vox_reg[0]);
    assign voxel_y   = $signed(out_vox_reg[1]);
    assign voxel_z   = $signed(out_vox_reg[2]);
    assign hit       = out_hit_reg;
    assign face      = out_face_reg;
    assign dist_sqr  = out_dsq_reg;

`ifndef SYNTHESIS
    a_hit_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> done_res)
        else $error("hit flagged on a voxel query");
    a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> (face == 3'd0) && (dist_sqr == 36'd0))
        else $error("query carries face or distance");
    a_final_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> (face[2:1] != 2'd3))
        else $error("final face out of range");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped while back end busy");
`endif

endmodule

@@ src/voxel_ray_traversal_dda_core.sv @@
`timescale 1ns / 1ps
// Reply item: registered in the queue, then stepped and loaded into the output register.
// Final result: three magnitude/square passes on one multiplier.
// Start item: 3 squares, 17 root iterations, and per axis a restoring divide
// (skipped for a zero direction component) plus one side-distance multiply.
// Reset (async, active low): idle, queue empty, max_steps = 64, no walk active.
module voxel_ray_traversal_dda_core
    import vrt_pkg::*;
#(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic               occupied,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               done_res,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z,
    output logic               hit,
    output logic [2:0]         face,
    output logic [35:0]        dist_sqr
);

    // Front: two-entry queue holding the items, tagged start vs. reply below.
    // Back: sequencer holding the walk state, the setup units and the
    // output register; replies to an idle block are dropped there.
    item_t item_in;
    head_t head;
    logic  pop;

    assign item_in.is_start = (func == FUNC_START);
    assign item_in.pos      = {pos_z, pos_y, pos_x};
    assign item_in.dir      = {dir_z, dir_y, dir_x};
    assign item_in.occupied = occupied;

    vrt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item_in  (item_in),
        .pop      (pop),
        .head     (head)
    );

    vrt_back
    #(
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .COORD_WIDTH   (COORD_WIDTH)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .done_res    (done_res),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .hit         (hit),
        .face        (face),
        .dist_sqr    (dist_sqr)
    );

endmodule
